>>> src/rle_pkg.sv
// Shared types and constants for the RGB LED effect engine.
package rle_pkg;
   localparam int CycleColors = 8;
   localparam int IdxW = $clog2(CycleColors);

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_WRITE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      FX_NONE    = 3'd0,
      FX_FADE    = 3'd1,
      FX_BREATHE = 3'd2,
      FX_RAINBOW = 3'd3,
      FX_FLASH   = 3'd4,
      FX_CYCLE   = 3'd5
   } fx_type;

   typedef enum logic [2:0] {
      CSR_KIND   = 3'd0,
      CSR_PERIOD = 3'd1,
      CSR_RED    = 3'd2,
      CSR_GREEN  = 3'd3,
      CSR_BLUE   = 3'd4,
      CSR_LENGTH = 3'd5
   } csr_type;

   // divider operand select
   typedef enum logic [2:0] {
      DIV_MOD  = 3'd0, // e mod d
      DIV_SCAL = 3'd1, // (rem*K)/d
      DIV_QUO  = 3'd2, // (e/d) mod n step 1: e/d
      DIV_IDX  = 3'd3, // q mod n
      DIV_FR   = 3'd4, // fade red
      DIV_FG   = 3'd5,
      DIV_FB   = 3'd6
   } dsel_type;

   typedef struct packed {
      logic     load_item;  // capture request, do start/stop/write/elapsed
      logic     div_go;
      dsel_type div_sel;
      logic     latch;      // latch divider result per div_sel
      logic     finish;     // compute color, load output
   } cmd_type;

   typedef struct packed {
      logic   div_done;
      fx_type kind;       // running effect after load
      logic   tick_run;   // item was a tick with effect running
      logic   fade_end;
   } sts_type;
endpackage

>>> src/rle_datapath.sv
// Datapath: effect state, cycle table, shared serial divider and color compute.
module rle_datapath import rle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [2:0]  cfg_kind,
   input  logic [31:0] cfg_period,
   input  logic [23:0] cfg_target,
   input  logic [3:0]  cfg_length,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_ms_advance,
   input  logic [2:0]  req_entry_index,
   input  logic [23:0] req_entry,
   output logic [23:0] shown,
   output logic        written,
   output logic        active
);
   fx_type      kind_ff, kind_in;
   logic [31:0] period_ff, period_in, elapsed_ff, elapsed_in;
   logic [23:0] fstart_ff, fstart_in, base_ff, base_in, shown_ff, shown_in;
   logic [3:0]  count_ff, count_in;
   logic        written_ff, written_in, tick_ff, tick_in;
   logic [23:0] table_mem [CycleColors];
   logic [23:0] tbl_rd_ff;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [7:0]  fo_ff [3];
   logic [2:0]  idx_ff, idx_in;

   // serial divider: 42-bit magnitude over 32-bit divisor
   logic [41:0] dq_ff, dq_in;
   logic [32:0] dr_ff, dr_in;
   logic [31:0] dd_ff, dd_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic        dbusy_ff, dbusy_in, ddone;
   logic        dneg_ff, dneg_in;
   logic [33:0] trial;

   logic [31:0] d_eff;
   assign d_eff = (period_ff == 32'd0) ? 32'd1 : period_ff;

   function automatic logic [7:0] ch(input logic [23:0] c, input int k);
      return c[23-8*k -: 8];
   endfunction

   // x / 255 for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   // divider operand mux
   logic [41:0] num;
   logic [31:0] den;
   logic        nneg;
   logic signed [9:0]  diff;
   logic [8:0]  mag;
   always_comb begin
      num  = '0;
      den  = d_eff;
      nneg = 1'b0;
      diff = '0;
      mag  = '0;
      case (cmd.div_sel)
         DIV_MOD: num = {10'd0, elapsed_ff};
         DIV_SCAL: num = (kind_ff == FX_BREATHE) ? 42'(rem_ff) * 42'd511 :
                                                   42'(rem_ff) * 42'd767;
         DIV_QUO: num = {10'd0, elapsed_ff};
         DIV_IDX: begin
            num = {10'd0, quo_ff};
            den = {28'd0, count_ff};
         end
         DIV_FR, DIV_FG, DIV_FB: begin
            diff = $signed({2'b0, ch(base_ff, int'(cmd.div_sel) - 4)})
                 - $signed({2'b0, ch(fstart_ff, int'(cmd.div_sel) - 4)});
            nneg = diff[9];
            mag  = nneg ? 9'(-diff) : diff[8:0];
            num  = 42'(mag) * 42'(elapsed_ff);
         end
         default: num = '0;
      endcase
   end

   assign trial = {dr_ff, dq_ff[41]} - {2'b0, dd_ff};
   always_comb begin
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; dcnt_in = dcnt_ff;
      dbusy_in = dbusy_ff; dneg_in = dneg_ff; ddone = 1'b0;
      if (cmd.div_go) begin
         dq_in = num; dr_in = '0; dd_in = den; dcnt_in = 6'd42;
         dbusy_in = 1'b1; dneg_in = nneg;
      end else if (dbusy_ff) begin
         if (!trial[33]) begin
            dr_in = trial[32:0];
            dq_in = {dq_ff[40:0], 1'b1};
         end else begin
            dr_in = {dr_ff[31:0], dq_ff[41]};
            dq_in = {dq_ff[40:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 6'd1;
         if (dcnt_ff == 6'd1) begin
            dbusy_in = 1'b0;
            ddone = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in; dneg_ff <= dneg_in;
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         dbusy_ff <= dbusy_in;
         dcnt_ff  <= dcnt_in;
      end
   end
   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else       done_ff <= ddone;
   end
   assign sts.div_done = done_ff;

   // latch divider results
   logic [7:0] fres;
   always_comb begin
      fres = dneg_ff ? 8'(ch(fstart_ff, int'(cmd.div_sel) - 4) - dq_ff[7:0]) :
                       8'(ch(fstart_ff, int'(cmd.div_sel) - 4) + dq_ff[7:0]);
   end
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; idx_in = idx_ff;
      if (cmd.latch) begin
         case (cmd.div_sel)
            DIV_MOD:  rem_in = dr_ff[31:0];
            DIV_SCAL: quo_in = dq_ff[31:0];
            DIV_QUO:  quo_in = dq_ff[31:0];
            DIV_IDX:  idx_in = dr_ff[2:0];
            default:  ;
         endcase
      end
   end
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      idx_ff <= idx_in;
      if (cmd.latch) begin
         case (cmd.div_sel)
            DIV_FR:  fo_ff[0] <= fres;
            DIV_FG:  fo_ff[1] <= fres;
            DIV_FB:  fo_ff[2] <= fres;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item && mode_type'(req_mode) == MODE_WRITE)
         table_mem[req_entry_index] <= req_entry;
      tbl_rd_ff <= table_mem[idx_ff];
   end

   // color for running effect
   logic [8:0]  level;
   logic [7:0]  o;
   logic [23:0] col;
   logic [15:0] prod [3];
   always_comb begin
      level = (quo_ff[8:0] < 9'd256) ? quo_ff[8:0] : 9'(9'd511 - quo_ff[8:0]);
      o = quo_ff[7:0];
      col = shown_ff;
      for (int k = 0; k < 3; k++)
         prod[k] = 16'(ch(base_ff, k) * level[7:0] + (level[8] ? ch(base_ff, k) : 8'd0) * 16'd256);
      case (kind_ff)
         FX_FADE: col = sts.fade_end ? base_ff : {fo_ff[0], fo_ff[1], fo_ff[2]};
         FX_BREATHE: col = {div255(prod[0]), div255(prod[1]), div255(prod[2])};
         FX_RAINBOW: begin
            case (quo_ff[9:8])
               2'd0:    col = {8'd255 - o, o, 8'd0};
               2'd1:    col = {8'd0, 8'd255 - o, o};
               default: col = {o, 8'd0, 8'd255 - o};
            endcase
         end
         FX_FLASH: col = (rem_ff < (d_eff >> 1)) ? base_ff : 24'd0;
         FX_CYCLE: col = tbl_rd_ff;
         default:  col = shown_ff;
      endcase
   end
   assign sts.fade_end = elapsed_ff >= period_ff;
   assign sts.kind = kind_ff;
   assign sts.tick_run = tick_ff;

   logic [3:0] clen;
   assign clen = (cfg_length > 4'(CycleColors)) ? 4'(CycleColors) : cfg_length;

   always_comb begin
      kind_in = kind_ff; period_in = period_ff; elapsed_in = elapsed_ff;
      fstart_in = fstart_ff; base_in = base_ff; shown_in = shown_ff;
      count_in = count_ff; written_in = written_ff; tick_in = tick_ff;
      if (cmd.load_item) begin
         written_in = 1'b0;
         tick_in = 1'b0;
         case (mode_type'(req_mode))
            MODE_TICK: if (kind_ff != FX_NONE) begin
               elapsed_in = elapsed_ff + 32'(req_ms_advance);
               tick_in = 1'b1;
            end
            MODE_START: begin
               kind_in = FX_NONE;
               case (fx_type'(cfg_kind))
                  FX_FADE: begin
                     if (cfg_period == 32'd0) begin
                        shown_in = cfg_target;
                        written_in = cfg_target != shown_ff;
                     end else begin
                        fstart_in = shown_ff; base_in = cfg_target;
                        period_in = cfg_period; elapsed_in = '0; kind_in = FX_FADE;
                     end
                  end
                  FX_BREATHE, FX_RAINBOW, FX_FLASH: begin
                     base_in = cfg_target; elapsed_in = '0; kind_in = fx_type'(cfg_kind);
                     period_in = (cfg_kind == FX_FLASH) ?
                        ((cfg_period < 32'd2) ? 32'd2 : cfg_period) :
                        ((cfg_period == 32'd0) ? 32'd1 : cfg_period);
                  end
                  FX_CYCLE: if (cfg_length != 4'd0) begin
                     count_in = clen; base_in = cfg_target; elapsed_in = '0;
                     kind_in = FX_CYCLE;
                     period_in = (cfg_period == 32'd0) ? 32'd1 : cfg_period;
                  end
                  default: ;
               endcase
            end
            MODE_STOP: kind_in = FX_NONE;
            default: ;
         endcase
      end
      if (cmd.finish && tick_ff) begin
         shown_in = col;
         written_in = col != shown_ff;
         if (kind_ff == FX_FADE && sts.fade_end) kind_in = FX_NONE;
      end
   end

   always_ff @(posedge clock) begin
      fstart_ff <= fstart_in; base_ff <= base_in;
      if (reset) begin
         kind_ff <= FX_NONE; period_ff <= '0; elapsed_ff <= '0; shown_ff <= '0;
         count_ff <= '0; written_ff <= 1'b0; tick_ff <= 1'b0;
      end else begin
         kind_ff <= kind_in; period_ff <= period_in; elapsed_ff <= elapsed_in;
         shown_ff <= shown_in; count_ff <= count_in; written_ff <= written_in;
         tick_ff <= tick_in;
      end
   end

   assign shown = shown_ff;
   assign written = written_ff;
   assign active = kind_ff != FX_NONE;

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      kind_ff == FX_NONE || period_ff != 32'd0)
      else $error("running effect with zero period");
   a_flash_period: assert property (@(posedge clock) disable iff (reset)
      kind_ff != FX_FLASH || period_ff >= 32'd2)
      else $error("flash period below two");
   a_count: assert property (@(posedge clock) disable iff (reset)
      kind_ff != FX_CYCLE || (count_ff != 4'd0 && count_ff <= 4'(CycleColors)))
      else $error("cycle count out of range");
endmodule

>>> src/rle_ctrl.sv
// Controller: sequences divider passes for one item and the result handshake.
module rle_ctrl import rle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DISP = 6'b000010,
      S_DIV  = 6'b000100,
      S_WAIT = 6'b001000,
      S_FIN  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   dsel_type  sel_ff, sel_in;
   logic      rd_ff, rd_in; // table read delay

   always_comb begin
      state_in = state_ff; sel_in = sel_ff; rd_in = 1'b0;
      cmd = '0;
      cmd.div_sel = sel_ff;
      req_ready = state_ff == S_IDLE;
      rsp_valid = state_ff == S_OUT;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load_item = 1'b1;
            state_in = S_DISP;
         end
         S_DISP: begin
            if (!sts.tick_run) state_in = S_FIN;
            else begin
               case (sts.kind)
                  FX_FADE:  sel_in = DIV_FR;
                  FX_CYCLE: sel_in = DIV_QUO;
                  default:  sel_in = DIV_MOD;
               endcase
               state_in = (sts.kind == FX_FADE && sts.fade_end) ? S_FIN : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_go = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: if (sts.div_done) begin
            cmd.latch = 1'b1;
            state_in = S_DIV;
            case (sel_ff)
               DIV_MOD: if (sts.kind == FX_FLASH) state_in = S_FIN;
                        else sel_in = DIV_SCAL;
               DIV_SCAL: state_in = S_FIN;
               DIV_QUO: sel_in = DIV_IDX;
               DIV_IDX: begin state_in = S_FIN; rd_in = 1'b1; end
               DIV_FR: sel_in = DIV_FG;
               DIV_FG: sel_in = DIV_FB;
               default: state_in = S_FIN;
            endcase
         end
         S_FIN: begin
            if (rd_ff) rd_in = 1'b0;
            else begin
               cmd.finish = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_WAIT && sel_ff == DIV_IDX && sts.div_done) rd_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (reset) begin
         state_ff <= S_IDLE; rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rd_ff <= rd_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_go_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |=> state_ff == S_WAIT)
      else $error("divider start without wait");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
endmodule

>>> src/rgb_led_effect_engine.sv
// Top level of the RGB LED effect engine.
// Non-tick items, ticks with no effect running and a tick that ends a fade go from the
// request transfer through dispatch and finish to rsp_valid; other ticks add 42-step
// divider passes: flash 1 pass, breathe/rainbow 2, cycle 2 plus a table read, fade 3.
// One item at a time; the next can be taken in the cycle after the result transfer.
// Synchronous reset clears the effect state and shown color to black; table is kept.
module rgb_led_effect_engine import rle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_ms_advance,
   input  logic [2:0]  req_entry_index,
   input  logic [7:0]  req_entry_red,
   input  logic [7:0]  req_entry_green,
   input  logic [7:0]  req_entry_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_led_red,
   output logic [7:0]  rsp_led_green,
   output logic [7:0]  rsp_led_blue,
   output logic        rsp_color_written,
   output logic        rsp_effect_active,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic [2:0]  kind_ff;
   logic [31:0] period_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [3:0]  length_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic [23:0] shown;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= '0; period_ff <= '0; red_ff <= '0; green_ff <= '0;
         blue_ff <= '0; length_ff <= '0;
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_KIND:   kind_ff <= csr_data[2:0];
            CSR_PERIOD: period_ff <= csr_data;
            CSR_RED:    red_ff <= csr_data[7:0];
            CSR_GREEN:  green_ff <= csr_data[7:0];
            CSR_BLUE:   blue_ff <= csr_data[7:0];
            CSR_LENGTH: length_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   rle_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd, .sts
   );

   rle_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .cfg_kind(kind_ff), .cfg_period(period_ff),
      .cfg_target({red_ff, green_ff, blue_ff}), .cfg_length(length_ff),
      .req_mode, .req_ms_advance, .req_entry_index,
      .req_entry({req_entry_red, req_entry_green, req_entry_blue}),
      .shown, .written(rsp_color_written), .active(rsp_effect_active)
   );

   assign rsp_led_red = shown[23:16];
   assign rsp_led_green = shown[15:8];
   assign rsp_led_blue = shown[7:0];
endmodule

>>> dv/rgb_led_effect_engine_tb.sv
// Testbench for rgb_led_effect_engine: random and directed items checked against a behavioral predictor.
`timescale 1ns / 100ps

module rgb_led_effect_engine_tb;
   import rle_pkg::*;

   typedef struct {
      mode_type    mode;
      logic [15:0] adv;
      logic [2:0]  idx;
      logic [7:0]  r, g, b;
   } led_item_type;

   typedef struct {
      logic [7:0] r, g, b;
      logic       written;
      logic       active;
   } led_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [15:0] req_ms_advance = '0;
   logic [2:0]  req_entry_index = '0;
   logic [7:0]  req_entry_red = '0;
   logic [7:0]  req_entry_green = '0;
   logic [7:0]  req_entry_blue = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_led_red, rsp_led_green, rsp_led_blue;
   logic        rsp_color_written, rsp_effect_active;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   rgb_led_effect_engine i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [2:0]  cfg_kind;
   logic [31:0] cfg_period;
   logic [7:0]  cfg_r, cfg_g, cfg_b;
   logic [3:0]  cfg_len;
   logic [2:0]  run_kind;
   logic [31:0] run_period, elapsed;
   logic [23:0] fade_from, shown, base_rgb;
   int unsigned run_count;
   logic [23:0] color_table [CycleColors];

   led_item_type  pending_items[$];
   led_state_type expected_leds[$];
   led_item_type  cur_item;
   int errors = 0, accepted = 0, checked = 0, phases = 0;
   bit calm = 1'b0;

   function automatic bit show_rgb(logic [23:0] c);
      if (c == shown) return 1'b0;
      shown = c;
      return 1'b1;
   endfunction

   function automatic logic [7:0] blend(logic [7:0] from, logic [7:0] to,
                                        logic [31:0] num, logic [31:0] den);
      longint diff, v;
      diff = longint'(to) - longint'(from);
      v = longint'(from) + (diff * $signed({32'd0, num})) / $signed({32'd0, den});
      return v[7:0];
   endfunction

   function automatic bit advance_effect(logic [15:0] adv);
      logic [31:0] d, rem;
      logic [63:0] scaled;
      logic [9:0]  level;
      logic [7:0]  o;
      logic [23:0] c;
      elapsed = elapsed + adv;
      d = (run_period == 0) ? 32'd1 : run_period;
      rem = elapsed % d;
      case (run_kind)
         FX_FADE: begin
            if (elapsed >= run_period) begin
               run_kind = FX_NONE;
               return show_rgb(base_rgb);
            end
            return show_rgb({blend(fade_from[23:16], base_rgb[23:16], elapsed, d),
                             blend(fade_from[15:8], base_rgb[15:8], elapsed, d),
                             blend(fade_from[7:0], base_rgb[7:0], elapsed, d)});
         end
         FX_BREATHE: begin
            scaled = ({32'd0, rem} * 64'd511) / {32'd0, d};
            level = (scaled < 256) ? scaled[9:0] : 10'(511 - scaled);
            return show_rgb({8'((base_rgb[23:16] * level) / 255),
                             8'((base_rgb[15:8] * level) / 255),
                             8'((base_rgb[7:0] * level) / 255)});
         end
         FX_RAINBOW: begin
            scaled = ({32'd0, rem} * 64'd767) / {32'd0, d};
            o = scaled[7:0];
            case (scaled[9:8])
               2'd0: c = {8'd255 - o, o, 8'd0};
               2'd1: c = {8'd0, 8'd255 - o, o};
               default: c = {o, 8'd0, 8'd255 - o};
            endcase
            return show_rgb(c);
         end
         FX_FLASH: return show_rgb((rem < d / 2) ? base_rgb : 24'd0);
         FX_CYCLE: begin
            if (run_count == 0 || run_count > CycleColors) return 1'b0;
            return show_rgb(color_table[(elapsed / d) % run_count]);
         end
         default: begin
            run_kind = FX_NONE;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic bit start_effect();
      logic [23:0] tgt;
      logic [31:0] p;
      tgt = {cfg_r, cfg_g, cfg_b};
      p = cfg_period;
      run_kind = FX_NONE;
      case (cfg_kind)
         FX_FADE: begin
            if (p == 0) return show_rgb(tgt);
            fade_from = shown;
         end
         FX_BREATHE, FX_RAINBOW, FX_CYCLE: if (p == 0) p = 1;
         FX_FLASH: if (p < 2) p = 2;
         default: return 1'b0;
      endcase
      if (cfg_kind == FX_CYCLE) begin
         if (cfg_len == 0) return 1'b0;
         run_count = (cfg_len > CycleColors) ? CycleColors : cfg_len;
      end
      base_rgb = tgt;
      run_period = p;
      elapsed = '0;
      run_kind = cfg_kind;
      return 1'b0;
   endfunction

   function automatic led_state_type predict_leds(led_item_type it);
      led_state_type s;
      bit w;
      w = 1'b0;
      case (it.mode)
         MODE_TICK:  if (run_kind != FX_NONE) w = advance_effect(it.adv);
         MODE_START: w = start_effect();
         MODE_STOP:  run_kind = FX_NONE;
         default:    color_table[it.idx] = {it.r, it.g, it.b};
      endcase
      s.r = shown[23:16];
      s.g = shown[15:8];
      s.b = shown[7:0];
      s.written = w;
      s.active = (run_kind != FX_NONE);
      return s;
   endfunction

   // driver
   always @(posedge clock) begin
      led_item_type nxt;
      bit           busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            expected_leds.push_back(predict_leds(cur_item));
            accepted++;
         end
         if (!busy) begin
            if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
               nxt = pending_items.pop_front();
               cur_item = nxt;
               req_mode <= nxt.mode;
               req_ms_advance <= nxt.adv;
               req_entry_index <= nxt.idx;
               req_entry_red <= nxt.r;
               req_entry_green <= nxt.g;
               req_entry_blue <= nxt.b;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      led_state_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_leds.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
               e = expected_leds.pop_front();
               checked++;
               if (rsp_led_red !== e.r || rsp_led_green !== e.g || rsp_led_blue !== e.b ||
                   rsp_color_written !== e.written || rsp_effect_active !== e.active) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at %0t: exp rgb %h %h %h w %b a %b, got %h %h %h w %b a %b",
                              $realtime, e.r, e.g, e.b, e.written, e.active,
                              rsp_led_red, rsp_led_green, rsp_led_blue,
                              rsp_color_written, rsp_effect_active);
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 31);
      end
   end

   task automatic write_regs(logic [2:0] kind, logic [31:0] period,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [3:0] len);
      logic [31:0] vals [6];
      vals = '{32'(kind), period, 32'(r), 32'(g), 32'(b), 32'(len)};
      for (int i = 0; i < 6; i++) begin
         csr_index <= 3'(i);
         csr_data <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_kind = kind;
      cfg_period = period;
      cfg_r = r;
      cfg_g = g;
      cfg_b = b;
      cfg_len = len;
   endtask

   task automatic push_item(mode_type m, logic [15:0] adv, logic [2:0] idx,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      led_item_type it;
      it.mode = m;
      it.adv = adv;
      it.idx = idx;
      it.r = r;
      it.g = g;
      it.b = b;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || expected_leds.size() != 0 || req_valid);
      repeat (150) @(posedge clock);
      phases++;
   endtask

   function automatic logic [15:0] rand_advance();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 16'($urandom_range(0, 20));
      if (sel < 75) return 16'($urandom_range(0, 400));
      if (sel < 90) return 16'($urandom);
      if (sel < 95) return 16'd0;
      return 16'hFFFF;
   endfunction

   function automatic logic [31:0] rand_period();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 32'($urandom_range(0, 60));
      if (sel < 75) return 32'($urandom_range(0, 3));
      if (sel < 85) return 32'($urandom_range(0, 2000));
      if (sel < 93) return $urandom;
      return 32'hFFFF_FFFF;
   endfunction

   initial begin
      int n, sel;
      cfg_kind = '0; cfg_period = '0; cfg_r = '0; cfg_g = '0; cfg_b = '0; cfg_len = '0;
      run_kind = FX_NONE; run_period = '0; elapsed = '0;
      fade_from = '0; shown = '0; base_rgb = '0; run_count = 0;
      foreach (color_table[i]) color_table[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill the table, idle tick and stop, zero-period and full fade, flash, cycle, bad kind
      for (int i = 0; i < CycleColors; i++)
         push_item(MODE_WRITE, 16'hFFFF, 3'(i), (i % 2) ? 8'hFF : 8'h00,
                   (i % 3) ? 8'hAA : 8'h55, 8'(i * 37));
      push_item(MODE_TICK, 16'd5, '0, '0, '0, '0);
      push_item(MODE_STOP, '0, '0, '0, '0, '0);
      drain();
      write_regs(FX_FADE, 32'd0, 8'hFF, 8'h00, 8'h80, 4'd0);
      push_item(MODE_START, '0, '0, '0, '0, '0);
      push_item(MODE_TICK, 16'd1, '0, '0, '0, '0);
      drain();
      write_regs(FX_FADE, 32'd10, 8'hFF, 8'hFF, 8'hFF, 4'd15);
      push_item(MODE_START, '0, '0, '0, '0, '0);
      push_item(MODE_TICK, 16'd3, '0, '0, '0, '0);
      push_item(MODE_TICK, 16'd7, '0, '0, '0, '0);
      push_item(MODE_TICK, 16'd1, '0, '0, '0, '0);
      drain();
      write_regs(FX_FLASH, 32'd1, 8'h12, 8'h34, 8'h56, 4'd8);
      push_item(MODE_START, '0, '0, '0, '0, '0);
      push_item(MODE_TICK, 16'd1, '0, '0, '0, '0);
      push_item(MODE_TICK, 16'd1, '0, '0, '0, '0);
      push_item(MODE_STOP, '0, '0, '0, '0, '0);
      drain();
      write_regs(FX_CYCLE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 4'd15);
      push_item(MODE_START, '0, '0, '0, '0, '0);
      push_item(MODE_TICK, 16'hFFFF, '0, '0, '0, '0);
      drain();
      write_regs(3'd7, 32'd0, 8'h00, 8'h00, 8'h00, 4'd0);
      push_item(MODE_START, '0, '0, '0, '0, '0);
      drain();

      // random phases
      while (accepted < 900) begin
         calm = (phases >= 12 && phases < 16);
         sel = $urandom_range(0, 9);
         write_regs((sel < 8) ? 3'($urandom_range(1, 5)) : 3'($urandom_range(0, 7)),
                    rand_period(), 8'($urandom), 8'($urandom), 8'($urandom),
                    4'($urandom_range(0, 15)));
         push_item(MODE_START, '0, '0, '0, '0, '0);
         n = $urandom_range(15, 40);
         for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 76)
               push_item(MODE_TICK, rand_advance(), '0, '0, '0, '0);
            else if (sel < 82)
               push_item(MODE_START, 16'($urandom), '0, '0, '0, '0);
            else if (sel < 87)
               push_item(MODE_STOP, 16'($urandom), 3'($urandom), '0, '0, '0);
            else
               push_item(MODE_WRITE, 16'($urandom), 3'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
         end
         drain();
      end
      calm = 1'b0;

      $display("covered %0d items in %0d phases, %0d results checked, %0d mismatches",
               accepted, phases, checked, errors);
      if (errors == 0 && expected_leds.size() == 0)
         $display("rgb_led_effect_engine_tb: clean");
      else
         $display("rgb_led_effect_engine_tb: errors");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", expected_leds.size());
      $display("rgb_led_effect_engine_tb: errors");
      $finish;
   end
endmodule
